// File: rtl/bfit_pkg.sv
// Package for the Bloom filter insert and test block.
// Holds the shared constants, configuration register codes and the status struct.
// Depends on nothing.
package bfit_pkg;

	// Width of the hash words and of the remainder unit's dividend.
	localparam int DVD_BITS = 64;

	// The bit store is organised in rows of 64 bits.
	localparam int ROW_BITS  = 64;
	localparam int ROW_SHIFT = 6;

	// Configuration port shape.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 17;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HASH_COUNT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LOG2_BITS  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TOTAL_BITS = 2'd2;

	// Register widths and reset values.
	localparam int HASH_COUNT_BITS = 6;
	localparam int LOG2_BITS_BITS  = 5;
	localparam logic [HASH_COUNT_BITS-1:0] HASH_COUNT_RST = 6'd7;
	localparam logic [LOG2_BITS_BITS-1:0]  LOG2_BITS_RST  = 5'd16;
	localparam logic [CFG_DATA_BITS-1:0]   TOTAL_BITS_RST = 17'd65536;

	// Status of the remainder unit as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/bloom_filter_insert_test.sv
// Top level of the Bloom filter insert and test block: sequencer and configuration.
// Uses bfit_pkg, bfit_divider and bfit_store.
//
// Usage. An input beat carries kind (0 test, 1 insert) and a hash pair. For each
// probe the running sum first_hash + i*second_hash is reduced to a bit address
// (masked by 2^log2_bits, or modulo total_bits when log2_bits is zero, then
// wrapped into the store), the bit is read and, for an insert, set. One output
// beat carries answer for every input beat, in order.
// In power-of-two mode each probe passes through an address state, which issues the
// read, and then a check state. In modulo mode with a nonzero total_bits each probe
// first waits for the shared remainder unit; a zero total_bits selects bit zero. In
// either mode an address beyond the store is wrapped by a pass through the same unit.
// A test stops at its first clear bit.
// One item is worked on at a time; in_ready is low while an item is in progress.
// The output register holds a finished answer while out_ready is low, and the next
// item may be accepted meanwhile; it waits at its end until the register frees.
// Reset: configuration and control registers take their reset values and the store
// is cleared by a pass over its ceil(STORE_BITS/64) rows, during which no item is
// accepted. Configuration beats are taken at any time and must come while idle.
module bloom_filter_insert_test
	import bfit_pkg::*;
#(
	parameter int STORE_BITS = 65536,
	parameter int MAX_PROBES = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [DVD_BITS-1:0]       first_hash,
	input  logic [DVD_BITS-1:0]       second_hash,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      answer
);

	localparam int ROWS = (STORE_BITS + ROW_BITS - 1) / ROW_BITS;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int AW   = $clog2(STORE_BITS);
	localparam int SB_W = $clog2(STORE_BITS + 1);
	localparam int DW   = (SB_W > CFG_DATA_BITS) ? SB_W : CFG_DATA_BITS;
	localparam int PW   = $clog2(MAX_PROBES + 1);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ADDR  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_WRAP  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [HASH_COUNT_BITS-1:0] hash_count_q;
	logic [LOG2_BITS_BITS-1:0]  log2_bits_q;
	logic [CFG_DATA_BITS-1:0]   total_bits_q;

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic                out_valid_q;
	logic                answer_q;
	logic [PW-1:0]       probe_q;
	logic [PW-1:0]       probes_q;
	logic [PW-1:0]       probes_sat;
	logic                kind_q;
	logic                result_q;
	logic [DVD_BITS-1:0] sum_q;
	logic [DVD_BITS-1:0] stride_q;
	logic [ROW_SHIFT-1:0] col_q;
	logic [RW-1:0]       row_q;

	logic [DVD_BITS-1:0] mask;
	logic [DVD_BITS-1:0] masked;
	logic                div_start;
	logic [DVD_BITS-1:0] div_dividend;
	logic [DW-1:0]       div_divisor;
	logic [DW-1:0]       div_rem;
	div_stat_t           div_stat;

	logic                rd_en;
	logic [AW-1:0]       pos_sel;
	logic [RW-1:0]       rd_row;
	logic [ROW_BITS-1:0] rd_data;
	logic                wr_en;
	logic [ROW_BITS-1:0] wr_data;
	logic                clear_busy;
	logic                bit_set;
	logic                last_probe;
	logic                out_load;

	// Configuration registers; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_count_q <= HASH_COUNT_RST;
			log2_bits_q  <= LOG2_BITS_RST;
			total_bits_q <= TOTAL_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HASH_COUNT: hash_count_q <= cfg_data[HASH_COUNT_BITS-1:0];
				CFG_LOG2_BITS:  log2_bits_q  <= cfg_data[LOG2_BITS_BITS-1:0];
				CFG_TOTAL_BITS: total_bits_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Probe count, saturated to the largest supported number of probes.
	assign probes_sat = ({1'b0, hash_count_q} > 7'(MAX_PROBES)) ? PW'(MAX_PROBES)
		: PW'(hash_count_q);

	// Power-of-two addressing mask.
	assign mask   = (64'd1 << log2_bits_q) - 64'd1;
	assign masked = sum_q & mask;

	assign in_ready   = (state_q == ST_IDLE) && !clear_busy;
	assign bit_set    = rd_data[col_q];
	assign last_probe = (PW'(probe_q + 1'b1) == probes_q);
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign rd_row     = RW'(pos_sel >> ROW_SHIFT);
	assign wr_en      = (state_q == ST_CHECK) && !bit_set && kind_q;
	assign wr_data    = rd_data | (ROW_BITS'(1) << col_q);

	// Sequencer: address reduction, read issue and probe stepping.
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = sum_q;
		div_divisor  = DW'(total_bits_q);
		rd_en        = 1'b0;
		pos_sel      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					state_d = (probes_sat == '0) ? ST_DONE : ST_ADDR;
				end
			end
			ST_ADDR: begin
				if (log2_bits_q != '0) begin
					if (masked >= 64'(STORE_BITS)) begin
						div_start    = 1'b1;
						div_dividend = masked;
						div_divisor  = DW'(STORE_BITS);
						state_d      = ST_WRAP;
					end else begin
						rd_en   = 1'b1;
						pos_sel = masked[AW-1:0];
						state_d = ST_CHECK;
					end
				end else if (total_bits_q == '0) begin
					rd_en   = 1'b1;
					state_d = ST_CHECK;
				end else begin
					div_start = 1'b1;
					state_d   = ST_MOD;
				end
			end
			ST_MOD: begin
				if (div_stat.done) begin
					if (div_rem >= DW'(STORE_BITS)) begin
						div_start    = 1'b1;
						div_dividend = DVD_BITS'(div_rem);
						div_divisor  = DW'(STORE_BITS);
						state_d      = ST_WRAP;
					end else begin
						rd_en   = 1'b1;
						pos_sel = AW'(div_rem);
						state_d = ST_CHECK;
					end
				end
			end
			ST_WRAP: begin
				if (div_stat.done) begin
					rd_en   = 1'b1;
					pos_sel = AW'(div_rem);
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if ((!bit_set && !kind_q) || last_probe) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_ADDR;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			probe_q     <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_valid && in_ready) begin
				probe_q <= '0;
			end else if (state_q == ST_CHECK) begin
				probe_q <= PW'(probe_q + 1'b1);
			end
		end
	end

	// Item registers, probe position and answer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q   <= kind;
			sum_q    <= first_hash;
			stride_q <= second_hash;
			probes_q <= probes_sat;
			result_q <= !kind;
		end else if (state_q == ST_CHECK) begin
			sum_q <= sum_q + stride_q;
			if (!bit_set) begin
				result_q <= kind_q;
			end
		end
		if (rd_en) begin
			col_q <= pos_sel[ROW_SHIFT-1:0];
			row_q <= rd_row;
		end
		if (out_load) begin
			answer_q <= result_q;
		end
	end

	assign out_valid = out_valid_q;
	assign answer    = answer_q;

	// Shared remainder unit.
	bfit_divider #(
		.DW(DW)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.stat    (div_stat),
		.rem     (div_rem)
	);

	// Bit store.
	bfit_store #(
		.ROWS(ROWS),
		.RW  (RW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_row    (rd_row),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_row    (row_q),
		.wr_data   (wr_data),
		.clear_busy(clear_busy)
	);

	// A check always follows a read issued in the previous cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> $past(rd_en))
		else $error("bit check without a preceding read");

	// The remainder unit is never restarted while it is still stepping.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("remainder unit started while busy");

	// No item is taken while the clearing pass runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !in_ready)
		else $error("item accepted during clearing pass");

	// Every address phase belongs to a probe within the item's probe count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR) |-> (probe_q < probes_q))
		else $error("probe counter ran past the probe count");

endmodule

// File: rtl/bfit_divider.sv
// Iterative remainder unit: reduces a 64-bit value modulo a divisor, one bit a cycle.
// Uses bfit_pkg for the dividend width and the status struct.
module bfit_divider
	import bfit_pkg::*;
#(
	parameter int DW = 25
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_BITS-1:0] dividend,
	input  logic [DW-1:0]       divisor,
	output div_stat_t           stat,
	output logic [DW-1:0]       rem
);

	localparam int CNT_BITS = $clog2(DVD_BITS + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DVD_BITS-1:0] dvd_q;
	logic [DW-1:0]       dvs_q;
	logic [DW-1:0]       rem_q;
	logic [DW:0]         rem_shift;
	logic                rem_ge;
	logic [DW-1:0]       rem_next;

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	always_comb begin
		rem_shift = {rem_q, dvd_q[DVD_BITS-1]};
		rem_ge    = rem_shift >= {1'b0, dvs_q};
		if (rem_ge) begin
			rem_next = DW'(rem_shift - {1'b0, dvs_q});
		end else begin
			rem_next = rem_shift[DW-1:0];
		end
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_BITS'(DVD_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

// File: rtl/bfit_store.sv
// Bit store of the Bloom filter: a row memory with registered read and a clearing pass.
// Uses bfit_pkg for the row width.
module bfit_store
	import bfit_pkg::*;
#(
	parameter int ROWS = 1024,
	parameter int RW   = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [RW-1:0]       rd_row,
	output logic [ROW_BITS-1:0] rd_data,
	input  logic                wr_en,
	input  logic [RW-1:0]       wr_row,
	input  logic [ROW_BITS-1:0] wr_data,
	output logic                clear_busy
);

	logic [ROW_BITS-1:0] mem [ROWS];
	logic [ROW_BITS-1:0] rd_data_q;
	logic                clr_q;
	logic [RW-1:0]       clr_row_q;
	logic                mem_we;
	logic [RW-1:0]       mem_wa;
	logic [ROW_BITS-1:0] mem_wd;

	// Clearing pass after reset: one row a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_q) begin
			if (clr_row_q == RW'(ROWS - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_row_q <= clr_row_q + 1'b1;
			end
		end
	end

	// The clearing pass owns the write port while it runs.
	always_comb begin
		if (clr_q) begin
			mem_we = 1'b1;
			mem_wa = clr_row_q;
			mem_wd = '0;
		end else begin
			mem_we = wr_en;
			mem_wa = wr_row;
			mem_wd = wr_data;
		end
	end

	// Memory with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_row];
		end
	end

	assign rd_data    = rd_data_q;
	assign clear_busy = clr_q;

endmodule

// File: tb/bloom_filter_insert_test_tb.sv
// Self-checking testbench for the Bloom filter insert and test block.
// Holds a scoreboard class with its own bit store and a top module that drives the block.
// Depends on bfit_pkg and bloom_filter_insert_test.

typedef enum bit {
	OP_TEST   = 1'b0,
	OP_INSERT = 1'b1
} bloom_op_e;

// Scoreboard: mirrors the bit store and the registers and predicts each answer.
class bloom_scoreboard #(int STORE_BITS = 65536, int MAX_PROBES = 32);
	bit        filter_bits [STORE_BITS];
	bit [5:0]  hash_count = bfit_pkg::HASH_COUNT_RST;
	bit [4:0]  log2_bits  = bfit_pkg::LOG2_BITS_RST;
	bit [16:0] total_bits = bfit_pkg::TOTAL_BITS_RST;
	bit        expected_answers [$];
	int        tests;
	int        inserts;
	int        answers_set;
	int        checked;
	int        errors;

	// Register writes; an unknown index leaves everything as it was.
	function void write_reg(logic [1:0] idx, logic [16:0] data);
		case (idx)
			bfit_pkg::CFG_HASH_COUNT: hash_count = data[5:0];
			bfit_pkg::CFG_LOG2_BITS:  log2_bits  = data[4:0];
			bfit_pkg::CFG_TOTAL_BITS: total_bits = data;
			default: ;
		endcase
	endfunction

	// Walks the probe sequence of one accepted input beat and queues its answer.
	function void note_item(bloom_op_e op, logic [63:0] first, logic [63:0] stride);
		int        probes;
		bit        result;
		bit [63:0] pos;
		probes = (hash_count > MAX_PROBES) ? MAX_PROBES : int'(hash_count);
		result = (op == OP_TEST);
		for (int i = 0; i < probes; i++) begin
			pos = first + stride * 64'(i);
			if (log2_bits != 0) begin
				pos = pos & ((64'd1 << log2_bits) - 64'd1);
			end else if (total_bits != 0) begin
				pos = pos % 64'(total_bits);
			end else begin
				pos = '0;
			end
			if (pos >= 64'(STORE_BITS))
				pos = pos % 64'(STORE_BITS);
			if (!filter_bits[int'(pos)]) begin
				if (op == OP_TEST) begin
					result = 1'b0;
					break;
				end
				result = 1'b1;
				filter_bits[int'(pos)] = 1'b1;
			end
		end
		if (op == OP_TEST)
			tests++;
		else
			inserts++;
		if (result)
			answers_set++;
		expected_answers.push_back(result);
	endfunction

	// Compares one output beat with the oldest outstanding answer.
	function void check_answer(logic actual);
		bit want;
		if (expected_answers.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: answer %0b arrived with nothing outstanding", actual);
			return;
		end
		want = expected_answers.pop_front();
		checked++;
		if (actual !== want) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: answer %0d: expected %0b, got %0b", checked, want, actual);
		end
	endfunction

	function int outstanding();
		return expected_answers.size();
	endfunction
endclass

module bloom_filter_insert_test_tb;
	import bfit_pkg::*;

	localparam int STORE_BITS    = 65536;
	localparam int MAX_PROBES    = 32;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 20000000;
	localparam int KEEP_KEYS     = 64;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_valid   = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic                      kind        = 1'b0;
	logic [DVD_BITS-1:0]       first_hash  = '0;
	logic [DVD_BITS-1:0]       second_hash = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic                      answer;

	bloom_scoreboard #(STORE_BITS, MAX_PROBES) sb = new;

	// Keys inserted lately, replayed as tests and as re-inserts.
	logic [127:0] inserted_keys [$];
	bit           smooth        = 1'b0;
	bit           hold_request  = 1'b0;
	int           settings_used = 0;
	int           modulo_used   = 0;

	bloom_filter_insert_test #(
		.STORE_BITS(STORE_BITS),
		.MAX_PROBES(MAX_PROBES)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.first_hash (first_hash),
		.second_hash(second_hash),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.answer     (answer)
	);

	always #10 clk = ~clk;

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Every accepted output beat is checked at the rising edge.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_answer(answer);
	end

	// Output side: random stalls, plus a long hold-off when asked for.
	initial begin : result_sink
		int stall_left;
		int gap;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				gap = (smooth || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
				if (gap > 0) begin
					out_ready  <= 1'b0;
					stall_left = gap - 1;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// One register write beat.
	task automatic write_register(input logic [1:0] idx, input logic [16:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every outstanding answer has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	// Brings the block to idle and loads a new filter setting; unused data bits are random.
	task automatic set_filter(input logic [5:0] hc, input logic [4:0] lb,
			input logic [16:0] tbits);
		drain();
		write_register(CFG_HASH_COUNT, {11'($urandom), hc});
		write_register(CFG_LOG2_BITS, {12'($urandom), lb});
		write_register(CFG_TOTAL_BITS, tbits);
		settings_used++;
		if (lb == 0)
			modulo_used++;
	endtask

	// One input beat, after a random gap; valid stays up across back-to-back beats.
	task automatic send_item(input bloom_op_e op, input logic [63:0] f, input logic [63:0] s);
		int gap;
		gap = smooth ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		kind        <= op;
		first_hash  <= f;
		second_hash <= s;
		do @(posedge clk); while (!in_ready);
		sb.note_item(op, f, s);
		if (op == OP_INSERT) begin
			inserted_keys.push_back({f, s});
			if (inserted_keys.size() > KEEP_KEYS)
				void'(inserted_keys.pop_front());
		end
	endtask

	// Random beat: fresh inserts, tests of known keys, tests of fresh keys, re-inserts.
	task automatic send_random_item();
		int           r;
		logic [63:0]  f;
		logic [63:0]  s;
		logic [127:0] key;
		r = $urandom_range(0, 99);
		f = {$urandom, $urandom};
		s = {$urandom, $urandom};
		if ($urandom_range(0, 15) == 0)
			s = '0;
		else if ($urandom_range(0, 15) == 0)
			s = ALL_ONES;
		if ($urandom_range(0, 31) == 0)
			f = $urandom_range(0, 1) ? ALL_ONES : '0;
		if (inserted_keys.size() == 0)
			r = 0;
		key = (inserted_keys.size() == 0) ? '0 :
			inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
		if (r < 40)
			send_item(OP_INSERT, f, s);
		else if (r < 75)
			send_item(OP_TEST, key[127:64], key[63:0]);
		else if (r < 90)
			send_item(OP_TEST, f, s);
		else
			send_item(OP_INSERT, key[127:64], key[63:0]);
	endtask

	// Main sequence: reset, directed cases, random settings, then the verdict.
	initial begin : stimulus
		logic [63:0] ka;
		logic [63:0] kb;
		logic [5:0]  hc;
		logic [4:0]  lb;
		logic [16:0] tbits;
		int          count;
		int          random_sent;
		int          phase_no;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Reset setting: empty store, repeated keys and the extremes of both hashes.
		send_item(OP_TEST, '0, '0);
		send_item(OP_INSERT, '0, '0);
		send_item(OP_INSERT, '0, '0);
		send_item(OP_TEST, '0, '0);
		send_item(OP_INSERT, ALL_ONES, ALL_ONES);
		send_item(OP_TEST, ALL_ONES, ALL_ONES);
		send_item(OP_TEST, ALL_ONES, '0);
		send_item(OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(OP_TEST, '0, ALL_ONES);

		// A write to the unused index must change nothing.
		drain();
		write_register(CFG_UNUSED, 17'h1FFFF);
		send_item(OP_TEST, ALL_ONES, ALL_ONES);

		// No probes at all.
		set_filter(6'd0, 5'd16, 17'd65536);
		send_item(OP_TEST, {$urandom, $urandom}, {$urandom, $urandom});
		send_item(OP_INSERT, {$urandom, $urandom}, {$urandom, $urandom});

		// Probe count above the maximum saturates.
		set_filter(6'd63, 5'd16, 17'd65536);
		ka = {$urandom, $urandom};
		kb = {$urandom, $urandom};
		send_item(OP_INSERT, ka, kb);
		send_item(OP_TEST, ka, kb);

		// Modulo mode with a zero divisor: every probe lands on bit zero.
		set_filter(6'd5, 5'd0, 17'd0);
		send_item(OP_TEST, {$urandom, $urandom}, {$urandom, $urandom});
		send_item(OP_INSERT, {$urandom, $urandom}, {$urandom, $urandom});
		send_item(OP_TEST, {$urandom, $urandom}, {$urandom, $urandom});

		// Addresses beyond the store, by mask and by divisor.
		set_filter(6'd3, 5'd31, 17'd65536);
		send_item(OP_INSERT, ALL_ONES, 64'd1);
		send_item(OP_TEST, ALL_ONES, 64'd1);
		set_filter(6'd3, 5'd0, 17'h1FFFF);
		ka = {$urandom, $urandom};
		kb = {$urandom, $urandom};
		send_item(OP_INSERT, ka, kb);
		send_item(OP_TEST, ka, kb);

		// A small divisor and the smallest mask.
		set_filter(6'd4, 5'd0, 17'd8);
		send_item(OP_INSERT, {$urandom, $urandom}, {$urandom, $urandom});
		send_item(OP_TEST, {$urandom, $urandom}, {$urandom, $urandom});
		set_filter(6'd2, 5'd1, 17'd8);
		send_item(OP_TEST, {$urandom, $urandom}, {$urandom, $urandom});

		// Random settings, each followed by a run of random beats.
		random_sent = 0;
		phase_no    = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				lb    = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(1, 31)) :
					5'($urandom_range(4, 16));
				hc    = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) :
					6'($urandom_range(1, 10));
				tbits = 17'($urandom);
				count = $urandom_range(40, 120);
			end else begin
				// Modulo mode is slow per probe, so few probes and short runs.
				lb    = 5'd0;
				tbits = ($urandom_range(0, 5) == 0) ? 17'($urandom_range(0, 7)) :
					17'($urandom_range(8, 131071));
				hc    = 6'($urandom_range(0, 4));
				count = $urandom_range(15, 40);
			end
			set_filter(hc, lb, tbits);
			smooth = ($urandom_range(0, 4) == 0);
			if (phase_no % 5 == 0)
				hold_request = 1'b1;
			repeat (count) begin
				send_random_item();
				random_sent++;
			end
			phase_no++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d tests and %0d inserts over %0d filter settings, %0d in modulo mode.",
			sb.tests, sb.inserts, settings_used, modulo_used);
		$display("Checked %0d answers, %0d of them set; %0d mismatches.",
			sb.checked, sb.answers_set, sb.errors);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("bloom_filter_insert_test_tb: done, clean");
		end else begin
			$display("bloom_filter_insert_test_tb: done, errors");
		end
		$finish;
	end

	// Cycle counter that ends a run which hangs.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d answers outstanding.",
			cycles, sb.outstanding());
		$display("bloom_filter_insert_test_tb: done, errors");
		$finish;
	end

endmodule
